@@ hw/rtl/rtgrc_pkg.sv @@
// Shared types and constants for the RTT-gradient rate control block.
package rtgrc_pkg;

	localparam int unsigned SampleW   = 24;
	localparam int unsigned RateW     = 32;
	localparam int unsigned AvgW      = 48;
	localparam int unsigned AccW      = 66;
	localparam int unsigned CntW      = 6;
	localparam int unsigned CfgIndexW = 3;
	localparam int unsigned CfgDataW  = 24;
	localparam int unsigned InDataW   = 48;
	localparam int unsigned OutDataW  = 72;
	localparam logic [2:0]  HaiEvents = 3'd5;

	// Configuration register indexes
	typedef enum logic [CfgIndexW-1:0] {
		CFG_EWMA_WEIGHT  = 3'd0,
		CFG_ADD_STEP     = 3'd1,
		CFG_DECREASE     = 3'd2,
		CFG_HIGH_THRESH  = 3'd3,
		CFG_LOW_THRESH   = 3'd4,
		CFG_SEGMENT      = 3'd5,
		CFG_USE_QUEUE    = 3'd6
	} cfg_index_t;

	// Decision codes reported with each result
	typedef enum logic [2:0] {
		DEC_LOW_INC  = 3'd0,
		DEC_HIGH_CUT = 3'd1,
		DEC_GRAD_INC = 3'd2,
		DEC_HAI_INC  = 3'd3,
		DEC_GRAD_CUT = 3'd4
	} decision_t;

	// Shared unit operations
	typedef enum logic {
		MDU_MUL = 1'b0,
		MDU_DIV = 1'b1
	} mdu_mode_t;

	// Request into the shared unit
	typedef struct packed {
		logic                  start;
		mdu_mode_t             mode;
		logic [AccW-1:0]       opa;
		logic [31:0]           opb;
		logic [SampleW-1:0]    rem;
		logic [CntW-1:0]       steps;
	} mdu_req_t;

endpackage

@@ hw/rtl/rtgrc_mdu.sv @@
// Iterative shift-add multiplier and restoring divider sharing one adder.
module rtgrc_mdu (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rtgrc_pkg::mdu_req_t            req,
	output logic                           done,
	output logic [rtgrc_pkg::AccW-1:0]     result,
	output logic [31:0]                    quotient
);

	logic                           busy_q;
	logic                           done_q;
	rtgrc_pkg::mdu_mode_t           mode_q;
	logic [rtgrc_pkg::AccW-1:0]     acc_q;
	logic [rtgrc_pkg::AccW-1:0]     opa_q;
	logic [31:0]                    opb_q;
	logic [rtgrc_pkg::CntW-1:0]     cnt_q;

	logic [rtgrc_pkg::AccW-1:0]     add_x;
	logic [rtgrc_pkg::AccW-1:0]     add_y;
	logic                           add_cin;
	logic [rtgrc_pkg::AccW-1:0]     add_sum;
	logic                           ge;

	// Operand select for the single adder
	always_comb begin
		if (mode_q == rtgrc_pkg::MDU_DIV) begin
			add_x   = {{(rtgrc_pkg::AccW-rtgrc_pkg::SampleW-1){1'b0}},
				acc_q[rtgrc_pkg::SampleW-1:0], opb_q[31]};
			add_y   = ~opa_q;
			add_cin = 1'b1;
		end else begin
			add_x   = {acc_q[rtgrc_pkg::AccW-2:0], 1'b0};
			add_y   = opb_q[31] ? opa_q : '0;
			add_cin = 1'b0;
		end
		add_sum = add_x + add_y + {{(rtgrc_pkg::AccW-1){1'b0}}, add_cin};
		ge      = ~add_sum[rtgrc_pkg::AccW-1];
	end

	// Step sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rtgrc_pkg::CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			mode_q <= req.mode;
			opa_q  <= req.opa;
			opb_q  <= req.opb;
			acc_q  <= (req.mode == rtgrc_pkg::MDU_DIV) ?
				{{(rtgrc_pkg::AccW-rtgrc_pkg::SampleW){1'b0}}, req.rem} : '0;
		end else if (busy_q) begin
			if (mode_q == rtgrc_pkg::MDU_DIV) begin
				acc_q <= ge ? add_sum : add_x;
				opb_q <= {opb_q[30:0], ge};
			end else begin
				acc_q <= add_sum;
				opb_q <= {opb_q[30:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign result   = acc_q;
	assign quotient = opb_q;

endmodule

@@ hw/rtl/rtt_gradient_rate_control.sv @@
// RTT-gradient rate control top level: registers, sequencer and stream ports.
//
//  channel  | direction | handshake          | content
//  s_*      | in        | s_tvalid/s_tready  | op (tuser), rtt_us, queue_depth
//  m_*      | out       | m_tvalid/m_tready  | rate_segments, window_bytes, decision
//  cfg_*    | in        | cfg_we             | register index and value
//
// One item at a time. A restart or empty sample ends in the PREP state. A sample
// runs the EWMA and window multiplies; a cut adds a multiply and, unless it wipes
// the rate, a divide and a second multiply, all on the serial shared unit.
// s_tready is high only while idle; a result is held until m_tready.
// Reset clears the control state and loads the default register values.
module rtt_gradient_rate_control (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// op [0]
	input  logic                                s_tuser,
	// rtt_us [23:0], queue_depth [47:24]
	input  logic [rtgrc_pkg::InDataW-1:0]       s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// rate_segments [31:0], window_bytes [63:32], decision [66:64], zero fill
	output logic [rtgrc_pkg::OutDataW-1:0]      m_tdata,
	input  logic                                cfg_we,
	input  logic [rtgrc_pkg::CfgIndexW-1:0]     cfg_index,
	input  logic [rtgrc_pkg::CfgDataW-1:0]      cfg_data
);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_PREP   = 10'b0000000010,
		ST_EWMA   = 10'b0000000100,
		ST_DECIDE = 10'b0000001000,
		ST_CMUL   = 10'b0000010000,
		ST_CDIV   = 10'b0000100000,
		ST_CAPP   = 10'b0001000000,
		ST_WIN    = 10'b0010000000,
		ST_WWAIT  = 10'b0100000000,
		ST_OUT    = 10'b1000000000
	} state_t;

	localparam int unsigned SW = rtgrc_pkg::SampleW;

	state_t state_q;

	// Configuration registers
	logic [15:0]   ewma_weight_q;
	logic [15:0]   add_step_q;
	logic [15:0]   decrease_q;
	logic [SW-1:0] high_q;
	logic [SW-1:0] low_q;
	logic [15:0]   segment_q;
	logic          use_queue_q;

	// Control state
	logic [rtgrc_pkg::RateW-1:0] rate_q;
	logic [SW-1:0]               min_q;
	logic [SW-1:0]               prev_q;
	logic                        prev_valid_q;
	logic [rtgrc_pkg::AvgW-1:0]  avg_q;
	logic [2:0]                  count_q;
	logic                        out_valid_q;

	// Item payload
	logic                        op_q;
	logic [SW-1:0]               rtt_q;
	logic [SW-1:0]               qocc_q;
	logic [SW-1:0]               meas_q;
	logic [SW-1:0]               div_q;
	logic [31:0]                 win_q;
	rtgrc_pkg::decision_t        dec_q;

	rtgrc_pkg::mdu_req_t         req;
	logic                        mdu_done;
	logic [rtgrc_pkg::AccW-1:0]  mdu_res;
	logic [31:0]                 mdu_quot;

	logic [SW-1:0]               meas;
	logic signed [SW:0]          diff;
	logic signed [49:0]          delta;
	logic [23:0]                 step;
	logic [26:0]                 step5;
	logic [39:0]                 cut_x;
	logic [SW-1:0]               min_div;
	logic                        avg_le0;
	logic [32:0]                 sum_inc1;
	logic [32:0]                 sum_inc5;

	// Sample selection, difference against the previous sample, and derived operands
	always_comb begin
		meas    = use_queue_q ? qocc_q : rtt_q;
		diff    = prev_valid_q ? ($signed({1'b0, meas}) - $signed({1'b0, prev_q})) : '0;
		delta   = $signed({{9{diff[SW]}}, diff, 16'b0}) - $signed({{2{avg_q[47]}}, avg_q});
		step    = {add_step_q, 8'b0};
		step5   = {1'b0, step, 2'b0} + {3'b0, step};
		cut_x   = (meas_q > high_q) ? {meas_q - high_q, 16'b0} : avg_q[39:0];
		min_div = (min_q == '0) ? SW'(1) : min_q;
		avg_le0 = avg_q[47] || (avg_q == '0);
		sum_inc1 = {1'b0, rate_q} + {9'b0, step};
		sum_inc5 = {1'b0, rate_q} + {6'b0, step5};
	end

	// Requests into the shared unit
	always_comb begin
		req       = '0;
		req.mode  = rtgrc_pkg::MDU_MUL;
		req.steps = rtgrc_pkg::CntW'(16);
		unique case (state_q)
			ST_PREP: begin
				req.start = !op_q && (rtt_q != '0);
				req.opa   = {{16{delta[49]}}, delta};
				req.opb   = {ewma_weight_q, 16'b0};
			end
			ST_DECIDE: begin
				req.start = !(meas_q < low_q) && ((meas_q > high_q) || !avg_le0);
				req.opa   = {26'b0, cut_x};
				req.opb   = {decrease_q, 16'b0};
			end
			ST_CMUL: begin
				req.start = mdu_done && (mdu_res[55:32] < div_q);
				req.mode  = rtgrc_pkg::MDU_DIV;
				req.opa   = {42'b0, div_q};
				req.opb   = mdu_res[31:0];
				req.rem   = mdu_res[55:32];
				req.steps = rtgrc_pkg::CntW'(32);
			end
			ST_CDIV: begin
				req.start = mdu_done;
				req.opa   = {34'b0, rate_q};
				req.opb   = mdu_quot;
				req.steps = rtgrc_pkg::CntW'(32);
			end
			ST_WIN: begin
				req.start = 1'b1;
				req.opa   = {34'b0, rate_q};
				req.opb   = {segment_q, 16'b0};
			end
			default: begin
				req.start = 1'b0;
			end
		endcase
	end

	rtgrc_mdu u_mdu (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.done     (mdu_done),
		.result   (mdu_res),
		.quotient (mdu_quot)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ewma_weight_q <= 16'd6554;
			add_step_q    <= 16'd1024;
			decrease_q    <= 16'd3277;
			high_q        <= SW'(4000);
			low_q         <= SW'(250);
			segment_q     <= 16'd1448;
			use_queue_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rtgrc_pkg::CFG_EWMA_WEIGHT: ewma_weight_q <= cfg_data[15:0];
				rtgrc_pkg::CFG_ADD_STEP:    add_step_q    <= cfg_data[15:0];
				rtgrc_pkg::CFG_DECREASE:    decrease_q    <= cfg_data[15:0];
				rtgrc_pkg::CFG_HIGH_THRESH: high_q        <= cfg_data;
				rtgrc_pkg::CFG_LOW_THRESH:  low_q         <= cfg_data;
				rtgrc_pkg::CFG_SEGMENT:     segment_q     <= cfg_data[15:0];
				rtgrc_pkg::CFG_USE_QUEUE:   use_queue_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Payload capture
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			op_q   <= s_tuser;
			rtt_q  <= s_tdata[23:0];
			qocc_q <= s_tdata[47:24];
		end
		if (state_q == ST_PREP) begin
			meas_q <= meas;
		end
		if (state_q == ST_DECIDE) begin
			div_q <= (meas_q > high_q) ? meas_q : min_div;
		end
		if (state_q == ST_WWAIT && mdu_done) begin
			win_q <= mdu_res[47:16];
		end
	end

	// Sequencer and rate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rate_q       <= '0;
			min_q        <= '1;
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
			avg_q        <= '0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
			dec_q        <= rtgrc_pkg::DEC_LOW_INC;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_PREP;
				end
				ST_PREP: begin
					if (op_q) begin
						rate_q       <= '0;
						min_q        <= '1;
						prev_q       <= '0;
						prev_valid_q <= 1'b0;
						avg_q        <= '0;
						count_q      <= '0;
						state_q      <= ST_IDLE;
					end else if (rtt_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						if (meas < min_q) min_q <= meas;
						prev_q       <= meas;
						prev_valid_q <= 1'b1;
						state_q      <= ST_EWMA;
					end
				end
				ST_EWMA: begin
					if (mdu_done) begin
						avg_q   <= avg_q + mdu_res[63:16];
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (meas_q < low_q) begin
						count_q <= '0;
						rate_q  <= sum_inc1[32] ? '1 : sum_inc1[31:0];
						dec_q   <= rtgrc_pkg::DEC_LOW_INC;
						state_q <= ST_WIN;
					end else if (meas_q > high_q) begin
						count_q <= '0;
						dec_q   <= rtgrc_pkg::DEC_HIGH_CUT;
						state_q <= ST_CMUL;
					end else if (avg_le0) begin
						if (count_q + 3'd1 == rtgrc_pkg::HaiEvents) begin
							count_q <= '0;
							rate_q  <= sum_inc5[32] ? '1 : sum_inc5[31:0];
							dec_q   <= rtgrc_pkg::DEC_HAI_INC;
						end else begin
							count_q <= count_q + 3'd1;
							rate_q  <= sum_inc1[32] ? '1 : sum_inc1[31:0];
							dec_q   <= rtgrc_pkg::DEC_GRAD_INC;
						end
						state_q <= ST_WIN;
					end else begin
						count_q <= '0;
						dec_q   <= rtgrc_pkg::DEC_GRAD_CUT;
						state_q <= ST_CMUL;
					end
				end
				ST_CMUL: begin
					// cut of one or more wipes the rate
					if (mdu_done) begin
						if (mdu_res[55:32] >= div_q) begin
							rate_q  <= '0;
							state_q <= ST_WIN;
						end else begin
							state_q <= ST_CDIV;
						end
					end
				end
				ST_CDIV: begin
					if (mdu_done) state_q <= ST_CAPP;
				end
				ST_CAPP: begin
					// rate - ceil(rate * c / 2^32)
					if (mdu_done) begin
						rate_q  <= rate_q - mdu_res[63:32] - {31'b0, |mdu_res[31:0]};
						state_q <= ST_WIN;
					end
				end
				ST_WIN: begin
					state_q <= ST_WWAIT;
				end
				ST_WWAIT: begin
					if (mdu_done) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						out_valid_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, dec_q, win_q, rate_q};

endmodule

@@ dv/tb_rtt_gradient_rate_control.sv @@
// Self-checking testbench for the RTT-gradient rate control block.
module tb_rtt_gradient_rate_control;

	localparam int unsigned WatchdogLimit = 20000;
	localparam int unsigned DrainCycles   = 200;

	logic                                clk;
	logic                                arst_n;
	logic                                s_tvalid;
	logic                                s_tready;
	// op [0]
	logic                                s_tuser;
	// rtt_us [23:0], queue_depth [47:24]
	logic [rtgrc_pkg::InDataW-1:0]       s_tdata;
	logic                                m_tvalid;
	logic                                m_tready;
	// rate_segments [31:0], window_bytes [63:32], decision [66:64], zero fill
	logic [rtgrc_pkg::OutDataW-1:0]      m_tdata;
	logic                                cfg_we;
	logic [rtgrc_pkg::CfgIndexW-1:0]     cfg_index;
	logic [rtgrc_pkg::CfgDataW-1:0]      cfg_data;

	typedef struct packed {
		rtgrc_pkg::decision_t decision;
		logic [31:0]          window;
		logic [31:0]          rate;
	} rate_result_t;

	rtt_gradient_rate_control u_top (.*);

	// Predictor copy of registers and state
	logic [15:0]        p_weight, p_step, p_beta, p_segment;
	logic [23:0]        p_high, p_low;
	logic               p_use_queue;
	logic [31:0]        p_rate;
	logic [23:0]        p_min, p_prev;
	logic               p_prev_valid;
	logic signed [63:0] p_avg;
	logic [2:0]         p_count;

	rate_result_t expected_q[$];
	int unsigned  error_count;
	int unsigned  idle_cycles;
	int unsigned  stall_left;
	bit           timed_out;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic signed [63:0] floor_shift16(logic signed [63:0] x);
		return x >>> 16;
	endfunction

	function automatic logic [31:0] cut_rate(logic [31:0] r, logic [63:0] c);
		logic [95:0] prod;
		if (c >= 64'h1_0000_0000) return 32'd0;
		prod = 96'(r) * 96'(64'h1_0000_0000 - c);
		return prod[63:32];
	endfunction

	function automatic logic [31:0] sat_add(logic [31:0] r, logic [63:0] inc);
		logic [63:0] s;
		s = 64'(r) + inc;
		return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	task automatic reset_predictor();
		p_weight = 16'd6554; p_step = 16'd1024; p_beta = 16'd3277;
		p_high = 24'd4000; p_low = 24'd250; p_segment = 16'd1448;
		p_use_queue = 1'b0;
		clear_history();
	endtask

	task automatic clear_history();
		p_rate = '0; p_min = '1; p_prev = '0; p_prev_valid = 1'b0;
		p_avg = '0; p_count = '0;
	endtask

	// Compute the rate update for one accepted sample
	task automatic predict_rate(logic op, logic [23:0] rtt, logic [23:0] qocc);
		logic [23:0]        m;
		logic signed [63:0] d, sum;
		logic [63:0]        step, c, win;
		rate_result_t       res;
		if (op) begin
			clear_history();
			return;
		end
		if (rtt == 0) return;
		m = p_use_queue ? qocc : rtt;
		step = 64'(p_step) << 8;
		if (m < p_min) p_min = m;
		d = p_prev_valid ? (64'(m) - 64'(p_prev)) : 64'sd0;
		p_prev = m;
		p_prev_valid = 1'b1;
		sum = $signed(64'(17'h10000 - p_weight)) * p_avg
			+ $signed(64'(p_weight)) * (d <<< 16);
		p_avg = floor_shift16(sum);
		if (m < p_low) begin
			p_count = '0;
			p_rate = sat_add(p_rate, step);
			res.decision = rtgrc_pkg::DEC_LOW_INC;
		end else if (m > p_high) begin
			c = (64'(p_beta) * (64'(m - p_high) << 16)) / 64'(m);
			p_count = '0;
			p_rate = cut_rate(p_rate, c);
			res.decision = rtgrc_pkg::DEC_HIGH_CUT;
		end else if (p_avg <= 0) begin
			p_count = p_count + 3'd1;
			if (p_count >= rtgrc_pkg::HaiEvents) begin
				p_count = '0;
				p_rate = sat_add(p_rate, step * 5);
				res.decision = rtgrc_pkg::DEC_HAI_INC;
			end else begin
				p_rate = sat_add(p_rate, step);
				res.decision = rtgrc_pkg::DEC_GRAD_INC;
			end
		end else begin
			c = (64'(p_beta) * 64'(p_avg)) / 64'((p_min != 0) ? p_min : 24'd1);
			p_rate = cut_rate(p_rate, c);
			p_count = '0;
			res.decision = rtgrc_pkg::DEC_GRAD_CUT;
		end
		win = (64'(p_rate) * 64'(p_segment)) >> 16;
		res.rate = p_rate;
		res.window = (win > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : win[31:0];
		expected_q.push_back(res);
	endtask

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Send one item and update the prediction on acceptance
	task automatic send_item(logic op, logic [23:0] rtt, logic [23:0] qocc);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {qocc, rtt};
		do @(posedge clk); while (!s_tready);
		predict_rate(op, rtt, qocc);
		// the block leaves idle after an accepted item, so s_tready drops
		s_tvalid <= 1'b0;
		@(posedge clk);
		repeat (gap_len()) @(posedge clk);
	endtask

	task automatic wait_drained();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// One register write per edge; the caller drops cfg_we after the last one
	task automatic write_reg(rtgrc_pkg::cfg_index_t idx, logic [23:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			rtgrc_pkg::CFG_EWMA_WEIGHT: p_weight = value[15:0];
			rtgrc_pkg::CFG_ADD_STEP:    p_step = value[15:0];
			rtgrc_pkg::CFG_DECREASE:    p_beta = value[15:0];
			rtgrc_pkg::CFG_HIGH_THRESH: p_high = value;
			rtgrc_pkg::CFG_LOW_THRESH:  p_low = value;
			rtgrc_pkg::CFG_SEGMENT:     p_segment = value[15:0];
			rtgrc_pkg::CFG_USE_QUEUE:   p_use_queue = value[0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [15:0] w, logic [15:0] st, logic [15:0] b,
			logic [23:0] hi, logic [23:0] lo, logic [15:0] seg, logic q);
		wait_drained();
		write_reg(rtgrc_pkg::CFG_EWMA_WEIGHT, 24'(w));
		write_reg(rtgrc_pkg::CFG_ADD_STEP, 24'(st));
		write_reg(rtgrc_pkg::CFG_DECREASE, 24'(b));
		write_reg(rtgrc_pkg::CFG_HIGH_THRESH, hi);
		write_reg(rtgrc_pkg::CFG_LOW_THRESH, lo);
		write_reg(rtgrc_pkg::CFG_SEGMENT, 24'(seg));
		write_reg(rtgrc_pkg::CFG_USE_QUEUE, 24'(q));
		cfg_we <= 1'b0;
	endtask

	// Directed: extremes, restart, empty sample, cuts
	task automatic test_directed();
		send_item(1'b0, 24'd100, 24'd0);
		send_item(1'b0, 24'd0, 24'hFFFFFF);
		repeat (6) send_item(1'b0, 24'd1000, 24'd5);
		send_item(1'b0, 24'd3000, 24'd0);
		send_item(1'b0, 24'hFFFFFF, 24'hFFFFFF);
		send_item(1'b0, 24'd4000, 24'd0);
		send_item(1'b1, 24'hFFFFFF, 24'hFFFFFF);
		send_item(1'b0, 24'd2000, 24'd0);
		send_item(1'b0, 24'd250, 24'd0);
		send_item(1'b0, 24'd249, 24'd0);
		send_item(1'b1, 24'd0, 24'd0);
	endtask

	// Extreme settings, queue mode with a zero minimum
	task automatic test_extreme_config();
		set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'd0, 16'hFFFF, 1'b1);
		send_item(1'b0, 24'd1, 24'd0);
		repeat (6) send_item(1'b0, 24'd7, 24'd0);
		send_item(1'b0, 24'd9, 24'd300);
		send_item(1'b0, 24'd9, 24'd10);
		set_config(16'd0, 16'd0, 16'd0, 24'd0, 24'hFFFFFF, 16'd1, 1'b0);
		send_item(1'b0, 24'hFFFFFE, 24'd3);
		send_item(1'b0, 24'hFFFFFF, 24'd3);
		send_item(1'b1, 24'd5, 24'd5);
	endtask

	task automatic random_burst(int unsigned count, logic [23:0] span);
		logic [23:0] base, rtt;
		base = 24'($urandom_range(1, span));
		repeat (count) begin
			case ($urandom_range(0, 19))
				0:       send_item(1'b1, 24'($urandom), 24'($urandom));
				1:       send_item(1'b0, 24'd0, 24'($urandom));
				2:       send_item(1'b0, 24'($urandom), 24'($urandom));
				default: begin
					rtt = base + 24'($urandom_range(0, span / 4)) - 24'(span / 8);
					if (rtt == 0) rtt = 24'd1;
					send_item(1'b0, rtt, 24'($urandom_range(0, span)));
				end
			endcase
		end
	endtask

	// Random phases under a range of register settings
	task automatic test_random();
		set_config(16'd6554, 16'd1024, 16'd3277, 24'd4000, 24'd250, 16'd1448, 1'b0);
		random_burst(500, 24'd5000);
		set_config(16'($urandom), 16'($urandom), 16'($urandom), 24'd60000, 24'd200,
			16'($urandom_range(1, 65535)), 1'b0);
		random_burst(400, 24'd80000);
		set_config(16'd32768, 16'd40000, 16'd65535, 24'd900, 24'd10, 16'd9000, 1'b1);
		random_burst(400, 24'd1000);
		set_config(16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
			24'($urandom_range(0, 3000)), 16'($urandom_range(1, 65535)), 1'b0);
		random_burst(500, 24'hFFFFFF);
	endtask

	// Result checker and receiver stalls
	always @(posedge clk) begin
		rate_result_t got, exp_res;
		if (m_tvalid && m_tready) begin
			got = m_tdata[66:0];
			if (expected_q.size() == 0) begin
				$error("unexpected result rate=%h", got.rate);
				error_count++;
			end else begin
				exp_res = expected_q.pop_front();
				if (got.rate !== exp_res.rate) begin
					$error("rate_segments exp %h got %h", exp_res.rate, got.rate);
					error_count++;
				end
				if (got.window !== exp_res.window) begin
					$error("window_bytes exp %h got %h", exp_res.window, got.window);
					error_count++;
				end
				if (got.decision !== exp_res.decision) begin
					$error("decision exp %0d got %0d", exp_res.decision, got.decision);
					error_count++;
				end
			end
		end
		// stalls of random length, mostly short
		if (arst_n) begin
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_tready   <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				stall_left <= gap_len();
				m_tready   <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog on accepted traffic
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WatchdogLimit && !timed_out) begin
				timed_out = 1'b1;
				$display("rtt_gradient_rate_control verification failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0; s_tvalid = 1'b0; s_tuser = 1'b0; s_tdata = '0; m_tready = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		error_count = 0; idle_cycles = 0; stall_left = 0; timed_out = 1'b0;
		reset_predictor();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_extreme_config();
		test_random();
		wait_drained();
		if (error_count == 0) begin
			$display("rtt_gradient_rate_control verification clean");
		end else begin
			$display("rtt_gradient_rate_control verification failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/rtgrc_pkg.sv
hw/rtl/rtgrc_mdu.sv
hw/rtl/rtt_gradient_rate_control.sv
dv/tb_rtt_gradient_rate_control.sv
